### hw/rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared constants, request codes and control structs of the cheat patcher.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int PAGE_SIZE       = 16384;
  localparam int NUM_PAGES       = 64;
  localparam int MAX_CHEATS      = 8;
  localparam int MAX_RESULTS     = 64;
  localparam int MAX_CHEAT_BYTES = 8;

  localparam int PAGE_BITS = $clog2(PAGE_SIZE);
  localparam int PIDX_W    = $clog2(NUM_PAGES);
  localparam int PCNT_W    = 33 - PAGE_BITS;
  localparam int CIDX_W    = $clog2(MAX_CHEATS);
  localparam int CCNT_W    = $clog2(MAX_CHEATS + 1);
  localparam int RCNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int BIDX_W    = $clog2(MAX_CHEAT_BYTES);
  localparam int LEN_W     = 4;

  localparam int IN_W  = 200;
  localparam int OUT_W = 40;

  typedef enum logic [1:0] {
    REQ_MAP   = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  typedef struct packed {
    logic load;
    logic map_step;
    logic add;
    logic flush;
    logic next_cheat;
    logic byte_start;
    logic byte_read;
    logic byte_take;
    logic byte_next;
    logic emit_resp;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic map_done;
    logic tick_ok;
    logic cheat_active;
    logic cheat_last;
    logic byte_last;
    logic hit;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/prc_ctrl.sv
// ----------------------------------------------------------------------------
// prc_ctrl
// Sequencer: decodes each request and steps the datapath through page
// map walks and the byte-by-byte cheat walk of a tick.
// ----------------------------------------------------------------------------
module prc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  prc_pkg::sts_t sts,
  output prc_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_MAP    = 8'b0000_0100,
    S_RESP   = 8'b0000_1000,
    S_CHEAT  = 8'b0001_0000,
    S_RD     = 8'b0010_0000,
    S_EV     = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req)
          prc_pkg::REQ_MAP: begin
            state_next = S_MAP;
          end
          prc_pkg::REQ_ADD: begin
            cmd.add    = 1'b1;
            state_next = S_RESP;
          end
          prc_pkg::REQ_FLUSH: begin
            cmd.flush  = 1'b1;
            state_next = S_RESP;
          end
          default: begin
            state_next = sts.tick_ok ? S_CHEAT : S_RESP;
          end
        endcase
      end
      S_MAP: begin
        if (sts.map_done) begin
          state_next = S_RESP;
        end else begin
          cmd.map_step = 1'b1;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit_resp = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_CHEAT: begin
        if (sts.cheat_active) begin
          cmd.byte_start = 1'b1;
          state_next     = S_RD;
        end else if (sts.cheat_last) begin
          state_next = S_FIN;
        end else begin
          cmd.next_cheat = 1'b1;
        end
      end
      S_RD: begin
        cmd.byte_read = 1'b1;
        state_next    = S_EV;
      end
      S_EV: begin
        if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
          cmd.byte_take = sts.hit;
          if (!sts.byte_last) begin
            cmd.byte_next = 1'b1;
            state_next    = S_RD;
          end else if (!sts.cheat_last) begin
            cmd.next_cheat = 1'b1;
            state_next     = S_CHEAT;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          if (sts.pend_valid) begin
            cmd.emit_last = 1'b1;
          end else begin
            cmd.emit_resp = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/prc_datapath.sv
// ----------------------------------------------------------------------------
// prc_datapath
// Page map memory, cheat table, walk counters, held write and output word.
// ----------------------------------------------------------------------------
module prc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  prc_pkg::cmd_t               cmd,
  output prc_pkg::sts_t               sts,
  input  logic [1:0]                  in_req,
  input  logic [prc_pkg::IN_W-1:0]    in_data,
  input  logic                        cfg_wen,
  input  logic                        cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_status,
  output logic                        out_wvalid,
  output logic [31:0]                 out_addr,
  output logic [7:0]                  out_data,
  output logic                        out_last
);

  localparam int PB = prc_pkg::PAGE_BITS;

  // request word
  logic [1:0]                req;
  logic                      present;
  logic [31:0]               c_addr;
  logic [63:0]               c_val;
  logic [prc_pkg::LEN_W-1:0] c_len;
  logic                      c_big;
  logic                      c_rep;

  // map walk
  logic [prc_pkg::PCNT_W-1:0] mp, mx, mpages;
  logic [31:0]                macc;
  logic [32:0]                size_round;

  // page map
  logic [31:0]                 page_mem [prc_pkg::NUM_PAGES];
  logic [prc_pkg::NUM_PAGES-1:0] mapped;

  // cheat table
  logic [31:0]               t_addr [prc_pkg::MAX_CHEATS];
  logic [63:0]               t_val  [prc_pkg::MAX_CHEATS];
  logic [prc_pkg::LEN_W-1:0] t_len  [prc_pkg::MAX_CHEATS];
  logic                      t_big  [prc_pkg::MAX_CHEATS];
  logic                      t_rep  [prc_pkg::MAX_CHEATS];
  logic [prc_pkg::CCNT_W-1:0] count;
  logic                       enabled;

  // tick walk
  logic [prc_pkg::CIDX_W-1:0] ci;
  logic [prc_pkg::BIDX_W-1:0] bx;
  logic [prc_pkg::RCNT_W-1:0] nw;
  logic                       resp_status;

  logic [31:0]               cur_addr;
  logic [prc_pkg::LEN_W-1:0] cur_len;
  logic [prc_pkg::LEN_W-1:0] rev_idx;
  logic [prc_pkg::BIDX_W-1:0] sel;
  logic [63:0]               cur_val;
  logic [31:0]               byte_addr;
  logic [prc_pkg::PIDX_W-1:0] rd_pg;

  logic [31:0]   rd_base;
  logic          rd_mapped;
  logic [PB-1:0] rd_off;
  logic [7:0]    rd_byte;

  logic          pend_valid;
  logic [31:0]   pend_addr;
  logic [7:0]    pend_data;

  logic          out_free;

  assign size_round = {1'b0, in_data[63:32]} + 33'(prc_pkg::PAGE_SIZE - 1);

  assign cur_addr  = t_addr[ci];
  assign cur_len   = t_len[ci];
  assign cur_val   = t_val[ci];
  assign byte_addr = cur_addr + 32'(bx);
  assign rd_pg     = byte_addr[PB +: prc_pkg::PIDX_W];
  assign rev_idx   = cur_len - prc_pkg::LEN_W'(1) - prc_pkg::LEN_W'(bx);
  assign sel       = t_big[ci] ? rev_idx[prc_pkg::BIDX_W-1:0] : bx;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    sts              = '0;
    sts.req          = prc_pkg::req_t'(req);
    sts.map_done     = (mx == mpages) || (mp >= prc_pkg::PCNT_W'(prc_pkg::NUM_PAGES));
    sts.tick_ok      = enabled && (count != '0);
    sts.cheat_active = t_rep[ci] && (cur_len != '0);
    sts.cheat_last   = (prc_pkg::CCNT_W'(ci) + prc_pkg::CCNT_W'(1)) == count;
    sts.byte_last    = (prc_pkg::LEN_W'(bx) + prc_pkg::LEN_W'(1)) == cur_len;
    sts.hit          = rd_mapped && (nw < prc_pkg::RCNT_W'(prc_pkg::MAX_RESULTS));
    sts.pend_valid   = pend_valid;
    sts.out_free     = out_free;
  end

  // request capture and map walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req     <= in_req;
      present <= in_data[96];
      c_addr  <= in_data[128:97];
      c_val   <= in_data[192:129];
      c_len   <= in_data[196:193];
      c_big   <= in_data[197];
      c_rep   <= in_data[198];
      mp      <= prc_pkg::PCNT_W'(in_data[31:PB]);
      mx      <= '0;
      mpages  <= size_round[32:PB];
      macc    <= in_data[95:64];
    end else if (cmd.map_step) begin
      mp   <= mp + prc_pkg::PCNT_W'(1);
      mx   <= mx + prc_pkg::PCNT_W'(1);
      macc <= macc + 32'(prc_pkg::PAGE_SIZE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_step) begin
      page_mem[mp[prc_pkg::PIDX_W-1:0]] <= present ? macc : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_read) begin
      rd_base <= page_mem[rd_pg];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mapped <= '0;
    end else if (cmd.map_step) begin
      mapped[mp[prc_pkg::PIDX_W-1:0]] <= present;
    end
  end

  // cheat table
  always_ff @(posedge clk) begin
    if (cmd.add && (count < prc_pkg::CCNT_W'(prc_pkg::MAX_CHEATS))) begin
      t_addr[count[prc_pkg::CIDX_W-1:0]] <= c_addr;
      t_val[count[prc_pkg::CIDX_W-1:0]]  <= c_val;
      t_len[count[prc_pkg::CIDX_W-1:0]]  <=
        (c_len > prc_pkg::LEN_W'(prc_pkg::MAX_CHEAT_BYTES)) ?
        prc_pkg::LEN_W'(prc_pkg::MAX_CHEAT_BYTES) : c_len;
      t_big[count[prc_pkg::CIDX_W-1:0]]  <= c_big;
      t_rep[count[prc_pkg::CIDX_W-1:0]]  <= c_rep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      enabled <= 1'b1;
    end else begin
      if (cfg_wen) begin
        enabled <= cfg_wdata;
      end
      if (cmd.flush) begin
        count <= '0;
      end else if (cmd.add && (count < prc_pkg::CCNT_W'(prc_pkg::MAX_CHEATS))) begin
        count <= count + prc_pkg::CCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      resp_status <= 1'b0;
    end else if (cmd.add) begin
      resp_status <= (count >= prc_pkg::CCNT_W'(prc_pkg::MAX_CHEATS));
    end
  end

  // tick walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ci <= '0;
      nw <= '0;
    end else begin
      if (cmd.next_cheat) begin
        ci <= ci + prc_pkg::CIDX_W'(1);
      end
      if (cmd.byte_take) begin
        nw <= nw + prc_pkg::RCNT_W'(1);
      end
    end
    if (cmd.byte_start) begin
      bx <= '0;
    end else if (cmd.byte_next) begin
      bx <= bx + prc_pkg::BIDX_W'(1);
    end
    if (cmd.byte_read) begin
      rd_off  <= byte_addr[PB-1:0];
      rd_byte <= cur_val[{sel, 3'b000} +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_mapped <= 1'b0;
    end else if (cmd.byte_read) begin
      rd_mapped <= mapped[rd_pg];
    end
  end

  // held write: goes out once the next write or the end of the walk is known
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.load || cmd.emit_last) begin
      pend_valid <= 1'b0;
    end else if (cmd.byte_take) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_take) begin
      pend_addr <= rd_base + 32'(rd_off);
      pend_data <= rd_byte;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_resp || cmd.emit_last || (cmd.byte_take && pend_valid)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_resp) begin
      out_status <= resp_status;
      out_wvalid <= 1'b0;
      out_addr   <= '0;
      out_data   <= '0;
      out_last   <= 1'b1;
    end else if (cmd.emit_last || (cmd.byte_take && pend_valid)) begin
      out_status <= 1'b0;
      out_wvalid <= 1'b1;
      out_addr   <= pend_addr;
      out_data   <= pend_data;
      out_last   <= cmd.emit_last;
    end
  end

endmodule

### hw/rtl/paged_ram_cheat_patcher_top.sv
// ----------------------------------------------------------------------------
// paged_ram_cheat_patcher_top
// Page map and cheat table; ticks turn replace cheats into host byte writes.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis word channel, one at a time: tready is high
// only while the sequencer is idle. Results leave on m_axis from a single
// output register, so a request can be taken while its last word waits.
// Map, add and flush give one word each; a tick gives one word per mapped
// byte of each replace cheat, tlast on the final one, or one empty word.
// A map writes one page map entry per page (at most 64); a tick visits
// each cheat and, for each byte of a replace cheat, does a page memory
// read and then a byte check. A stalled receiver holds the output word
// and the walk waits for it. Reset clears the page valid bits and the
// cheat count and enables cheats; no clearing pass is needed. cfg_wen
// writes cheats_enabled; the user must use it only while no request is
// in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module paged_ram_cheat_patcher_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // region_start, region_size, region_base, region_present, cheat_address,
  // cheat_value, cheat_length, cheat_big_endian, cheat_is_replace, zero pad
  input  logic [prc_pkg::IN_W-1:0] s_axis_tdata,
  // req_type
  input  logic [1:0]               s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // write_address, write_data
  output logic [prc_pkg::OUT_W-1:0] m_axis_tdata,
  // status, write_valid
  output logic [1:0]               m_axis_tuser,
  output logic                     m_axis_tlast,
  input  logic                     cfg_wen,
  input  logic                     cfg_wdata
);

  prc_pkg::cmd_t cmd;
  prc_pkg::sts_t sts;

  logic        out_status;
  logic        out_wvalid;
  logic [31:0] out_addr;
  logic [7:0]  out_data;

  prc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_req     (s_axis_tuser),
    .in_data    (s_axis_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (out_status),
    .out_wvalid (out_wvalid),
    .out_addr   (out_addr),
    .out_data   (out_data),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_data, out_addr};
  assign m_axis_tuser = {out_wvalid, out_status};

endmodule

### hw/rtl/prc_checker.sv
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks of the cheat patcher, bound to the top level.
// ----------------------------------------------------------------------------
module prc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [prc_pkg::OUT_W-1:0] m_axis_tdata,
  input logic [1:0]                m_axis_tuser,
  input logic                      m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in flight");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("word without a write is not a clean final word");

  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
    else $error("rejected add carries a write");

endmodule

bind paged_ram_cheat_patcher_top prc_checker u_prc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
